// File: hdl/lsmd_pkg.sv
// shared types and constants for the lidar sector minimum distance block
package lsmd_pkg;

	localparam int BYTE_W     = 8;
	localparam int POS_W      = 3;
	localparam int FRAME_LEN  = 5;
	localparam int ANGLE_W    = 9;
	localparam int DIST_W     = 14;
	localparam int SLOT_W     = 15;
	localparam int MIN_OUT_W  = 12;
	localparam int IDX_W      = 5;

	// slot reset value and per-sector depths
	localparam logic [SLOT_W-1:0] SLOT_RESET = 15'd32639;
	localparam logic [SLOT_W-1:0] MIN_INIT   = 15'h7FFF;
	localparam int SIDE_DEPTH = 20;
	localparam int WIDE_DEPTH = 21;
	localparam logic [IDX_W-1:0] SIDE_LAST_IDX = 5'(SIDE_DEPTH - 1);
	localparam logic [IDX_W-1:0] WIDE_LAST_IDX = 5'(WIDE_DEPTH - 1);

	// sector angle bounds in degrees
	localparam logic [ANGLE_W-1:0] LEFT_LO  = 9'd330;
	localparam logic [ANGLE_W-1:0] LEFT_HI  = 9'd349;
	localparam logic [ANGLE_W-1:0] RIGHT_LO = 9'd11;
	localparam logic [ANGLE_W-1:0] RIGHT_HI = 9'd30;
	localparam logic [ANGLE_W-1:0] REAR_LO  = 9'd170;
	localparam logic [ANGLE_W-1:0] REAR_HI  = 9'd190;
	localparam logic [ANGLE_W-1:0] FRONT_LO = 9'd350;
	localparam logic [ANGLE_W-1:0] FRONT_HI = 9'd359;
	localparam logic [ANGLE_W-1:0] FRONT_WRAP_HI = 9'd10;
	localparam logic [ANGLE_W-1:0] FRONT_WRAP_OFS = 9'd10;

	localparam logic [BYTE_W-1:0] THRESH_RESET = 8'd254;

	// reciprocal of ten: (x * 52429) >> 19 is exact for x below 2^18
	localparam int DIV10_SHIFT = 19;
	localparam int PROD_W = SLOT_W + 16;
	localparam logic [PROD_W-1:0] DIV10_MULT = 31'd52429;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STORE,
		ST_SCAN,
		ST_DIV,
		ST_OUT
	} lsmd_state_t;

	typedef struct packed {
		logic take_byte;
		logic store;
		logic scan_start;
		logic scan_step;
		logic finish;
	} lsmd_cmd_t;

	typedef struct packed {
		logic frame_end;
		logic scan_last;
	} lsmd_status_t;

endpackage

// File: hdl/lsmd_ctrl.sv
// controller state machine: sequences byte intake, slot store, sector scan, divide and output
module lsmd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  lsmd_pkg::lsmd_status_t status,
	output lsmd_pkg::lsmd_cmd_t  cmd
);
	import lsmd_pkg::*;

	lsmd_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.take_byte = 1'b1;
					if (status.frame_end) begin
						state_d = ST_STORE;
					end
				end
			end
			ST_STORE: begin
				cmd.store      = 1'b1;
				cmd.scan_start = 1'b1;
				state_d        = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.finish = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				// leading bytes of the next frame may enter while the result waits
				in_stall = status.frame_end;
				if (in_valid && !status.frame_end) begin
					cmd.take_byte = 1'b1;
				end
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/lsmd_dpath.sv
// datapath: frame assembly, sector slot registers, minimum scan and scaling
module lsmd_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lsmd_pkg::lsmd_cmd_t                cmd,
	output lsmd_pkg::lsmd_status_t             status,
	input  logic [lsmd_pkg::BYTE_W-1:0]        rx_byte,
	input  logic                               cfg_wr_en,
	input  logic [lsmd_pkg::BYTE_W-1:0]        cfg_wr_data,
	output logic [lsmd_pkg::MIN_OUT_W-1:0]     front_min_div10,
	output logic [lsmd_pkg::MIN_OUT_W-1:0]     left_min_div10,
	output logic [lsmd_pkg::MIN_OUT_W-1:0]     right_min_div10,
	output logic [lsmd_pkg::MIN_OUT_W-1:0]     rear_min_div10,
	output logic                               near_front,
	output logic                               near_left,
	output logic                               near_right,
	output logic                               near_rear,
	output logic                               frame_check_ok,
	output logic                               sample_stored
);
	import lsmd_pkg::*;

	logic [BYTE_W-1:0]  frame_q [4];
	logic [POS_W-1:0]   pos_q;
	logic [BYTE_W-1:0]  thresh_q;
	logic               ok_q;
	logic               stored_q;
	logic [ANGLE_W-1:0] angle_q;
	logic [DIST_W-1:0]  dist_q;
	logic [IDX_W-1:0]   idx_q;

	logic [SLOT_W-1:0] left_q  [SIDE_DEPTH];
	logic [SLOT_W-1:0] right_q [SIDE_DEPTH];
	logic [SLOT_W-1:0] front_q [WIDE_DEPTH];
	logic [SLOT_W-1:0] rear_q  [WIDE_DEPTH];

	logic [SLOT_W-1:0] min_front_q, min_left_q, min_right_q, min_rear_q;

	logic               frame_end;
	logic               frame_ok;
	logic [ANGLE_W-1:0] angle_new;
	logic [DIST_W-1:0]  dist_new;

	logic               hit_left, hit_right, hit_rear, hit_front_hi, hit_front_lo;
	logic [ANGLE_W-1:0] ofs_left, ofs_right, ofs_rear, ofs_front_hi, ofs_front_lo;
	logic               dist_nz;
	logic [SLOT_W-1:0]  dist_slot;

	logic [PROD_W-1:0]  prod_front, prod_left, prod_right, prod_rear;

	assign frame_end = (pos_q == POS_W'(FRAME_LEN - 1));
	assign status.frame_end = frame_end;
	assign status.scan_last = (idx_q == WIDE_LAST_IDX);

	// frame check and field extraction on the closing byte
	assign frame_ok  = (frame_q[0][0] ^ frame_q[0][1]) & frame_q[1][0];
	assign angle_new = {frame_q[2], frame_q[1][7]};
	assign dist_new  = {rx_byte, frame_q[3][7:2]};

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_wr_en) begin
			thresh_q <= cfg_wr_data;
		end
	end

	// byte position counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.take_byte) begin
			pos_q <= frame_end ? '0 : pos_q + 1'b1;
		end
	end

	// frame byte buffer and captured frame fields
	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			if (!frame_end) begin
				frame_q[pos_q[1:0]] <= rx_byte;
			end else begin
				ok_q    <= frame_ok;
				angle_q <= angle_new;
				dist_q  <= dist_new;
			end
		end
	end

	// sector decode of the captured angle
	always_comb begin
		hit_left     = angle_q inside {[LEFT_LO:LEFT_HI]};
		hit_right    = angle_q inside {[RIGHT_LO:RIGHT_HI]};
		hit_rear     = angle_q inside {[REAR_LO:REAR_HI]};
		hit_front_hi = angle_q inside {[FRONT_LO:FRONT_HI]};
		hit_front_lo = (angle_q <= FRONT_WRAP_HI);
		ofs_left     = angle_q - LEFT_LO;
		ofs_right    = angle_q - RIGHT_LO;
		ofs_rear     = angle_q - REAR_LO;
		ofs_front_hi = angle_q - FRONT_LO;
		ofs_front_lo = angle_q + FRONT_WRAP_OFS;
		dist_nz      = (dist_q != '0);
		dist_slot    = SLOT_W'(dist_q);
	end

	// sector slot registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SIDE_DEPTH; i++) begin
				left_q[i]  <= SLOT_RESET;
				right_q[i] <= SLOT_RESET;
			end
			for (int i = 0; i < WIDE_DEPTH; i++) begin
				front_q[i] <= SLOT_RESET;
				rear_q[i]  <= SLOT_RESET;
			end
			stored_q <= 1'b0;
		end else if (cmd.store) begin
			stored_q <= ok_q && dist_nz &&
				(hit_left | hit_right | hit_rear | hit_front_hi | hit_front_lo);
			if (ok_q && dist_nz) begin
				if (hit_left) begin
					left_q[ofs_left[IDX_W-1:0]] <= dist_slot;
				end else if (hit_right) begin
					right_q[ofs_right[IDX_W-1:0]] <= dist_slot;
				end else if (hit_rear) begin
					rear_q[ofs_rear[IDX_W-1:0]] <= dist_slot;
				end else if (hit_front_hi) begin
					front_q[ofs_front_hi[IDX_W-1:0]] <= dist_slot;
				end else if (hit_front_lo) begin
					front_q[ofs_front_lo[IDX_W-1:0]] <= dist_slot;
				end
			end
		end
	end

	// scan index and running minima, one slot of each sector per cycle, the side sectors stopping after their last slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.scan_start) begin
			idx_q <= '0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			min_front_q <= MIN_INIT;
			min_left_q  <= MIN_INIT;
			min_right_q <= MIN_INIT;
			min_rear_q  <= MIN_INIT;
		end else if (cmd.scan_step) begin
			if (front_q[idx_q] < min_front_q) begin
				min_front_q <= front_q[idx_q];
			end
			if (rear_q[idx_q] < min_rear_q) begin
				min_rear_q <= rear_q[idx_q];
			end
			if (idx_q <= SIDE_LAST_IDX) begin
				if (left_q[idx_q] < min_left_q) begin
					min_left_q <= left_q[idx_q];
				end
				if (right_q[idx_q] < min_right_q) begin
					min_right_q <= right_q[idx_q];
				end
			end
		end
	end

	// divide by ten through the reciprocal
	assign prod_front = PROD_W'(min_front_q) * DIV10_MULT;
	assign prod_left  = PROD_W'(min_left_q)  * DIV10_MULT;
	assign prod_right = PROD_W'(min_right_q) * DIV10_MULT;
	assign prod_rear  = PROD_W'(min_rear_q)  * DIV10_MULT;

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			front_min_div10 <= prod_front[DIV10_SHIFT +: MIN_OUT_W];
			left_min_div10  <= prod_left[DIV10_SHIFT +: MIN_OUT_W];
			right_min_div10 <= prod_right[DIV10_SHIFT +: MIN_OUT_W];
			rear_min_div10  <= prod_rear[DIV10_SHIFT +: MIN_OUT_W];
			near_front      <= (min_front_q < SLOT_W'(thresh_q));
			near_left       <= (min_left_q  < SLOT_W'(thresh_q));
			near_right      <= (min_right_q < SLOT_W'(thresh_q));
			near_rear       <= (min_rear_q  < SLOT_W'(thresh_q));
			frame_check_ok  <= ok_q;
			sample_stored   <= stored_q;
		end
	end

endmodule

// File: hdl/lidar_sector_min_distance.sv
// top level of the lidar sector minimum distance block
//
// channel   direction  handshake                 payload
// in        input      in_valid / in_stall       rx_byte
// out       output     out_valid / out_stall     four sector minima / 10, near flags, status
// cfg       input      cfg_wr_en                 cfg_wr_data (near threshold)
//
// the first four bytes of a frame take one cycle each
// the fifth byte starts a slot store and then a scan of all four sectors in parallel;
// the minima are then divided by ten into the result register and out_valid rises
// while a result is stalled, the first four bytes of the next frame are still taken
// reset puts every slot at 32639, the threshold at 254 and the byte count at zero
module lidar_sector_min_distance (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [lsmd_pkg::BYTE_W-1:0]    rx_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [lsmd_pkg::MIN_OUT_W-1:0] front_min_div10,
	output logic [lsmd_pkg::MIN_OUT_W-1:0] left_min_div10,
	output logic [lsmd_pkg::MIN_OUT_W-1:0] right_min_div10,
	output logic [lsmd_pkg::MIN_OUT_W-1:0] rear_min_div10,
	output logic                           near_front,
	output logic                           near_left,
	output logic                           near_right,
	output logic                           near_rear,
	output logic                           frame_check_ok,
	output logic                           sample_stored,
	input  logic                           cfg_wr_en,
	input  logic [lsmd_pkg::BYTE_W-1:0]    cfg_wr_data
);
	import lsmd_pkg::*;

	lsmd_cmd_t    cmd;
	lsmd_status_t status;

	// controller
	lsmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath
	lsmd_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.rx_byte         (rx_byte),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.front_min_div10 (front_min_div10),
		.left_min_div10  (left_min_div10),
		.right_min_div10 (right_min_div10),
		.rear_min_div10  (rear_min_div10),
		.near_front      (near_front),
		.near_left       (near_left),
		.near_right      (near_right),
		.near_rear       (near_rear),
		.frame_check_ok  (frame_check_ok),
		.sample_stored   (sample_stored)
	);

	// a stored sample only comes from a frame that passed its check
	a_stored_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!sample_stored || frame_check_ok))
		else $error("sample stored on a failed frame");

	// the front near flag bounds the scaled minimum by the largest threshold
	a_near_front_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && near_front) |-> (front_min_div10 <= 12'd25))
		else $error("front near flag with large minimum");

	// input is held off in the cycle before a fresh result appears
	a_stall_before_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("input taken while result was being computed");

endmodule
